>>> rtl/core/set_assoc_cache_lru_tags_unit_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the lru tag unit
// clocked on clk; the plain form is gated by reset, the _rst form is not
// ---------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_TAGS_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SALRU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SALRU_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SALRU_ASSERT(lbl, prop, msg)
`define SALRU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/core/salru_pkg.sv
// ---------------------------------------------------------------------------
// salru_pkg
// shared widths, register codes and status types of the lru tag unit
// ---------------------------------------------------------------------------
package salru_pkg;

	localparam int ADDR_W       = 64;
	// set and block fields take at least one bit each
	localparam int TAG_W        = ADDR_W - 2;
	localparam int CNT_W        = 32;
	localparam int SET_BITS_W   = 4;
	localparam int WAYS_W       = 4;
	localparam int BLOCK_BITS_W = 6;
	localparam int CFG_DATA_W   = 6;
	localparam int CFG_IDX_W    = 2;

	localparam int MAX_SETS_DEF = 256;
	localparam int MAX_WAYS_DEF = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

	typedef struct packed {
		logic hit;
		logic evict;
	} lookup_t;

endpackage

>>> rtl/core/salru_req_if.sv
// ---------------------------------------------------------------------------
// salru_req_if
// request channel: address and modify flag with valid/ready
// ---------------------------------------------------------------------------
interface salru_req_if;
	logic                        valid;
	logic                        ready;
	logic [salru_pkg::ADDR_W-1:0] address;
	logic                        is_modify;

	modport source (output valid, address, is_modify, input ready);
	modport sink   (input valid, address, is_modify, output ready);
endinterface

>>> rtl/core/salru_rsp_if.sv
// ---------------------------------------------------------------------------
// salru_rsp_if
// result channel: hit/evict flags and running totals with valid/ready
// ---------------------------------------------------------------------------
interface salru_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       was_hit;
	logic                       was_evicted;
	logic [salru_pkg::CNT_W-1:0] hits_total;
	logic [salru_pkg::CNT_W-1:0] misses_total;
	logic [salru_pkg::CNT_W-1:0] evictions_total;

	modport source (output valid, was_hit, was_evicted, hits_total, misses_total,
		evictions_total, input ready);
	modport sink   (input valid, was_hit, was_evicted, hits_total, misses_total,
		evictions_total, output ready);
endinterface

>>> rtl/core/set_assoc_cache_lru_tags_unit.sv
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_tags_unit
// lru tag store of a set-associative cache with hit/miss/eviction totals
// ---------------------------------------------------------------------------
//  port    | dir | handshake   | content
//  --------+-----+-------------+------------------------------------------
//  req     | in  | valid/ready | address, is_modify
//  rsp     | out | valid/ready | was_hit, was_evicted, three running totals
//  cfg_*   | in  | write only  | set_bits, ways_in_use, block_bits
//
//  one request per cycle while results are taken; it waits in the first stage, then its result is registered
//  the set is read from the tag ram at accept and written back as the request leaves the first stage;
//  a request to the set just written takes the written row from a bypass
//  reset clears per-set valid flags, so the store reads empty with no sweep
//  a result not taken holds the second stage, then req.ready drops
// ---------------------------------------------------------------------------
`include "set_assoc_cache_lru_tags_unit_macros.svh"

module set_assoc_cache_lru_tags_unit #(
	parameter int MAX_SETS = salru_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = salru_pkg::MAX_WAYS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	salru_req_if.sink                           req,
	salru_rsp_if.source                         rsp
);

	localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
	localparam int IDX_W  = SMAX;
	localparam int SETS   = 1 << SMAX;
	localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W  = 1 + salru_pkg::TAG_W + RANK_W;
	localparam int ROW_W  = MAX_WAYS * WAY_W;
	localparam int CW     = salru_pkg::CNT_W;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v, input logic en);
		sat_inc = (en && v != '1) ? v + CW'(1) : v;
	endfunction

	// configuration
	logic [salru_pkg::SET_BITS_W-1:0]   set_bits_q;
	logic [salru_pkg::WAYS_W-1:0]       ways_q;
	logic [salru_pkg::BLOCK_BITS_W-1:0] block_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= salru_pkg::SET_BITS_W'(1);
			ways_q       <= salru_pkg::WAYS_W'(1);
			block_bits_q <= salru_pkg::BLOCK_BITS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				salru_pkg::CFG_SET_BITS: begin
					set_bits_q <= cfg_wdata[salru_pkg::SET_BITS_W-1:0];
				end
				salru_pkg::CFG_WAYS: begin
					ways_q <= cfg_wdata[salru_pkg::WAYS_W-1:0];
				end
				salru_pkg::CFG_BLOCK_BITS: begin
					block_bits_q <= cfg_wdata[salru_pkg::BLOCK_BITS_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// address split
	logic [salru_pkg::SET_BITS_W-1:0]   s_raw;
	logic [salru_pkg::SET_BITS_W-1:0]   s_eff;
	logic [salru_pkg::BLOCK_BITS_W-1:0] b_eff;
	logic [6:0]                         shift;
	logic [salru_pkg::ADDR_W-1:0]       tag_full;
	logic [salru_pkg::ADDR_W-1:0]       idx_full;
	logic [salru_pkg::TAG_W-1:0]        tag_in;
	logic [IDX_W-1:0]                   idx_in;

	always_comb begin
		s_raw    = (set_bits_q == '0) ? salru_pkg::SET_BITS_W'(1) : set_bits_q;
		s_eff    = (32'(s_raw) > SMAX) ? salru_pkg::SET_BITS_W'(SMAX) : s_raw;
		b_eff    = (block_bits_q == '0) ? salru_pkg::BLOCK_BITS_W'(1) : block_bits_q;
		shift    = 7'(s_eff) + 7'(b_eff);
		tag_full = req.address >> shift;
		tag_in   = (shift >= 7'd64) ? '0 : tag_full[salru_pkg::TAG_W-1:0];
		idx_full = req.address >> b_eff;
		idx_in   = idx_full[IDX_W-1:0] & ~({IDX_W{1'b1}} << s_eff);
	end

	// handshake
	logic s1_vld_q;
	logic rsp_vld_q;
	logic fire_s1;
	logic accept;

	assign fire_s1   = s1_vld_q && (!rsp_vld_q || rsp.ready);
	assign req.ready = !s1_vld_q || fire_s1;
	assign accept    = req.valid && req.ready;

	// tag ram and per-set written flags
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] wr_row;
	logic [SETS-1:0]  row_vld_q;

	logic [salru_pkg::TAG_W-1:0] tag_s1;
	logic [IDX_W-1:0]            idx_s1;
	logic                        mod_s1;
	logic                        rv_s1;
	logic                        byp_s1;
	logic [ROW_W-1:0]            byp_row_s1;
	logic                        same_set;

	salru_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (idx_s1),
		.wdata (wr_row),
		.re    (accept),
		.raddr (idx_in),
		.rdata (ram_rdata)
	);

	assign same_set = fire_s1 && (idx_s1 == idx_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (fire_s1) begin
			row_vld_q[idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (accept) begin
			s1_vld_q <= 1'b1;
		end else if (fire_s1) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tag_s1     <= tag_in;
			idx_s1     <= idx_in;
			mod_s1     <= req.is_modify;
			rv_s1      <= row_vld_q[idx_in] | same_set;
			byp_s1     <= same_set;
			byp_row_s1 <= wr_row;
		end
	end

	// lookup and update
	salru_pkg::lookup_t stat;

	salru_update #(
		.MAX_WAYS (MAX_WAYS)
	) u_update (
		.row_in    (byp_s1 ? byp_row_s1 : ram_rdata),
		.row_valid (rv_s1),
		.tag       (tag_s1),
		.ways_cfg  (ways_q),
		.row_out   (wr_row),
		.status    (stat)
	);

	// totals and result register
	logic [CW-1:0] hits_q;
	logic [CW-1:0] misses_q;
	logic [CW-1:0] evicts_q;
	logic [CW-1:0] hits_one;
	logic          was_hit_q;
	logic          was_evicted_q;

	// the second access of a modify always hits and leaves the set as is
	assign hits_one = sat_inc(hits_q, stat.hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q    <= '0;
			misses_q  <= '0;
			evicts_q  <= '0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (fire_s1) begin
				hits_q    <= sat_inc(hits_one, mod_s1);
				misses_q  <= sat_inc(misses_q, ~stat.hit);
				evicts_q  <= sat_inc(evicts_q, stat.evict);
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			was_hit_q     <= stat.hit;
			was_evicted_q <= stat.evict;
		end
	end

	assign rsp.valid           = rsp_vld_q;
	assign rsp.was_hit         = was_hit_q;
	assign rsp.was_evicted     = was_evicted_q;
	assign rsp.hits_total      = hits_q;
	assign rsp.misses_total    = misses_q;
	assign rsp.evictions_total = evicts_q;

	`SALRU_ASSERT(a_ready_only_when_full, !req.ready |-> (s1_vld_q && rsp_vld_q), "ready low with free stage")
	`SALRU_ASSERT(a_result_follows, fire_s1 |=> rsp_vld_q, "result lost after lookup")
	`SALRU_ASSERT(a_evict_is_miss, (fire_s1 && stat.evict) |-> !stat.hit, "eviction on a hit")
	`SALRU_ASSERT(a_hits_step, 1'b1 |=> (hits_q - $past(hits_q)) <= CW'(2), "hit total jumped")
	`SALRU_ASSERT_RST(a_reset_empty, !arst_n |-> (row_vld_q == '0 && !s1_vld_q), "state not cleared in reset")

endmodule

>>> rtl/core/salru_ram.sv
// ---------------------------------------------------------------------------
// salru_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module salru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/salru_update.sv
// ---------------------------------------------------------------------------
// salru_update
// tag match, victim choice and lru rank update for one set
// ---------------------------------------------------------------------------
module salru_update #(
	parameter int MAX_WAYS = salru_pkg::MAX_WAYS_DEF,
	localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
	localparam int WAY_W   = 1 + salru_pkg::TAG_W + RANK_W,
	localparam int ROW_W   = MAX_WAYS * WAY_W
) (
	input  logic [ROW_W-1:0]               row_in,
	input  logic                           row_valid,
	input  logic [salru_pkg::TAG_W-1:0]    tag,
	input  logic [salru_pkg::WAYS_W-1:0]   ways_cfg,
	output logic [ROW_W-1:0]               row_out,
	output salru_pkg::lookup_t             status
);

	localparam int WI_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int CNT_W = $clog2(MAX_WAYS + 1);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
	localparam int TAG_OFS = RANK_W;
	localparam int VLD_OFS = RANK_W + salru_pkg::TAG_W;

	logic [CNT_W-1:0]               n_ways;
	logic [MAX_WAYS-1:0]            vld_raw;
	logic [MAX_WAYS-1:0]            live;
	logic [RANK_W-1:0]              rank [MAX_WAYS];
	logic [salru_pkg::TAG_W-1:0]    tags [MAX_WAYS];
	logic                           hit;
	logic                           have_inv;
	logic                           have_vic;
	logic [WI_W-1:0]                hit_way;
	logic [WI_W-1:0]                inv_way;
	logic [WI_W-1:0]                vic_way;
	logic [RANK_W-1:0]              vic_rank;
	logic [WI_W-1:0]                sel_way;
	logic                           was_valid;
	logic [RANK_W-1:0]              old_rank;

	always_comb begin
		if (ways_cfg == '0) begin
			n_ways = CNT_W'(1);
		end else if (32'(ways_cfg) > MAX_WAYS) begin
			n_ways = CNT_W'(MAX_WAYS);
		end else begin
			n_ways = CNT_W'(ways_cfg);
		end
	end

	always_comb begin
		hit      = 1'b0;
		have_inv = 1'b0;
		have_vic = 1'b0;
		hit_way  = '0;
		inv_way  = '0;
		vic_way  = '0;
		vic_rank = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			rank[i]    = row_in[i*WAY_W + 0 +: RANK_W];
			tags[i]    = row_in[i*WAY_W + TAG_OFS +: salru_pkg::TAG_W];
			vld_raw[i] = row_valid & row_in[i*WAY_W + VLD_OFS];
			live[i]    = vld_raw[i] && (n_ways > CNT_W'(i));
			if (live[i] && tags[i] == tag && !hit) begin
				hit     = 1'b1;
				hit_way = WI_W'(i);
			end
			if (!vld_raw[i] && (n_ways > CNT_W'(i)) && !have_inv) begin
				have_inv = 1'b1;
				inv_way  = WI_W'(i);
			end
			// oldest valid line, lowest way on equal ranks
			if (live[i] && (!have_vic || rank[i] > vic_rank)) begin
				have_vic = 1'b1;
				vic_way  = WI_W'(i);
				vic_rank = rank[i];
			end
		end
	end

	always_comb begin
		if (hit) begin
			sel_way = hit_way;
		end else if (have_inv) begin
			sel_way = inv_way;
		end else begin
			sel_way = vic_way;
		end
		was_valid = hit | ~have_inv;
		old_rank  = rank[sel_way];
	end

	always_comb begin
		row_out = row_in;
		for (int i = 0; i < MAX_WAYS; i++) begin
			row_out[i*WAY_W + VLD_OFS] = vld_raw[i];
			if (sel_way == WI_W'(i)) begin
				row_out[i*WAY_W + VLD_OFS]                     = 1'b1;
				row_out[i*WAY_W + TAG_OFS +: salru_pkg::TAG_W] = tag;
				row_out[i*WAY_W + 0 +: RANK_W]                 = '0;
			end else if (live[i] && (!was_valid || rank[i] < old_rank)
				&& rank[i] != RANK_MAX) begin
				row_out[i*WAY_W + 0 +: RANK_W] = rank[i] + RANK_W'(1);
			end
		end
	end

	assign status.hit   = hit;
	assign status.evict = ~hit & ~have_inv;

endmodule
